// ===== rtl/pdsp_pkg.sv =====
package pdsp_pkg;

    localparam int DUR_W             = 21;
    localparam int PART_W            = 15;
    localparam int MAX_PART_DEFAULT  = 32767;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [DUR_W-1:0] pulse_len;
        logic             level;
        logic             last;
    } pdsp_in_t;

    typedef struct packed {
        logic [PART_W-1:0] first_duration;
        logic              first_level;
        logic [PART_W-1:0] second_duration;
        logic              second_level;
        logic              last_symbol;
        logic              error;
    } pdsp_out_t;

    typedef struct packed {
        logic [DUR_W-1:0] pulse_len;
        logic             level;
        logic             last;
        logic             is_error;
    } pdsp_cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
    } pdsp_q_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pdsp_q_stat_t;

endpackage

// ===== rtl/pulse_duration_symbol_packer_unit.sv =====
// pulse duration symbol packer
// input queue side: drive item and push; a transfer happens on a clock edge
// with push high and full low. each item is a duration, a level and a last
// mark. output queue side: while empty is low, result holds the oldest symbol
// word; a transfer happens on a clock edge with pop high and empty low.
// an item is classified at the front (zero durations and dropped sequences)
// and queued unless dropped; the back unit cuts it into parts, one part per
// cycle while the output register can take a word, and packs two parts per
// symbol word into a one-entry output register. an item is first loaded
// from the queue, then split; a padding word follows the last part of a
// sequence when that part is left unpaired.
// when the receiver stalls, the output register holds its word, the back unit
// waits on the next word and the queue fills until full rises.
// reset clears the waiting part, the dropping mark and the queue and empties
// the output register; no item is lost across the two sides during stalls.
module pulse_duration_symbol_packer_unit #(
    parameter int MAX_PART_DURATION = pdsp_pkg::MAX_PART_DEFAULT,
    parameter int QUEUE_DEPTH       = pdsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  pdsp_pkg::pdsp_in_t  item,
    output logic                empty,
    input  logic                pop,
    output pdsp_pkg::pdsp_out_t result
);
    import pdsp_pkg::*;

    pdsp_q_req_t  q_req;
    pdsp_q_stat_t q_stat;
    pdsp_cmd_t    wr_cmd;
    pdsp_cmd_t    rd_cmd;
    logic         q_push;
    logic         q_pop;

    assign q_req.push = q_push;
    assign q_req.pop  = q_pop;

    pdsp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_stat (q_stat),
        .q_push (q_push),
        .cmd    (wr_cmd)
    );

    pdsp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (q_req),
        .wr_data (wr_cmd),
        .rd_data (rd_cmd),
        .stat    (q_stat)
    );

    pdsp_back #(
        .MAX_PART_DURATION (MAX_PART_DURATION)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rd_cmd),
        .q_empty (q_stat.empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// ===== rtl/pdsp_front.sv =====
module pdsp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  pdsp_pkg::pdsp_in_t      item,
    input  pdsp_pkg::pdsp_q_stat_t  q_stat,
    output logic                    q_push,
    output pdsp_pkg::pdsp_cmd_t     cmd
);
    import pdsp_pkg::*;

    logic discard_reg;
    logic discard_next;
    logic accept;
    logic zero_dur;

    assign full     = q_stat.full;
    assign accept   = push && !q_stat.full;
    assign zero_dur = (item.pulse_len == '0);
    assign q_push   = accept && !discard_reg;

    always_comb
    begin
        cmd.pulse_len   = item.pulse_len;
        cmd.level       = item.level;
        cmd.last        = item.last;
        cmd.is_error    = zero_dur;
    end

    // drop the rest of a sequence after a zero duration
    always_comb
    begin
        discard_next = discard_reg;
        if (accept)
        begin
            if (discard_reg || zero_dur)
            begin
                discard_next = !item.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg <= 1'b0;
        end
        else
        begin
            discard_reg <= discard_next;
        end
    end

endmodule

// ===== rtl/pdsp_cmd_fifo.sv =====
module pdsp_cmd_fifo #(
    parameter int DEPTH = pdsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pdsp_pkg::pdsp_q_req_t   req,
    input  pdsp_pkg::pdsp_cmd_t     wr_data,
    output pdsp_pkg::pdsp_cmd_t     rd_data,
    output pdsp_pkg::pdsp_q_stat_t  stat
);
    import pdsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    pdsp_cmd_t       slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign stat.full  = (count_reg == FullCnt);
    assign stat.empty = (count_reg == '0);
    assign do_wr      = req.push && !stat.full;
    assign do_rd      = req.pop && !stat.empty;
    assign rd_data    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/pdsp_back.sv =====
module pdsp_back #(
    parameter int MAX_PART_DURATION = pdsp_pkg::MAX_PART_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pdsp_pkg::pdsp_cmd_t     cmd,
    input  logic                    q_empty,
    output logic                    q_pop,
    output pdsp_pkg::pdsp_out_t     result,
    output logic                    empty,
    input  logic                    pop
);
    import pdsp_pkg::*;

    localparam logic [DUR_W-1:0]  MaxPartWide = DUR_W'(MAX_PART_DURATION);
    localparam logic [PART_W-1:0] MaxPart     = PART_W'(MAX_PART_DURATION);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_PAD,
        ST_ERR
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [DUR_W-1:0]  rem_reg;
    logic [DUR_W-1:0]  rem_next;
    logic              lvl_reg;
    logic              lvl_next;
    logic              last_reg;
    logic              last_next;
    logic              half_reg;
    logic              half_next;
    logic [PART_W-1:0] pend_dur_reg;
    logic [PART_W-1:0] pend_dur_next;
    logic              pend_lvl_reg;
    logic              pend_lvl_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pdsp_out_t         out_reg;
    pdsp_out_t         out_next;

    logic              out_ok;
    logic              long_part;
    logic [PART_W-1:0] part;
    logic [DUR_W-1:0]  rem_after;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign out_ok    = !out_valid_reg || pop;
    assign long_part = (rem_reg > MaxPartWide);
    assign part      = long_part ? MaxPart : rem_reg[PART_W-1:0];
    assign rem_after = rem_reg - DUR_W'(part);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        lvl_next       = lvl_reg;
        last_next      = last_reg;
        half_next      = half_reg;
        pend_dur_next  = pend_dur_reg;
        pend_lvl_next  = pend_lvl_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    rem_next   = cmd.pulse_len;
                    lvl_next   = cmd.level;
                    last_next  = cmd.last;
                    state_next = cmd.is_error ? ST_ERR : ST_SPLIT;
                end
            end
            ST_ERR:
            begin
                if (out_ok)
                begin
                    out_next       = '0;
                    out_next.error = 1'b1;
                    out_valid_next = 1'b1;
                    half_next      = 1'b0;
                    pend_dur_next  = '0;
                    pend_lvl_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_SPLIT:
            begin
                if (half_reg)
                begin
                    if (out_ok)
                    begin
                        out_next.first_duration  = pend_dur_reg;
                        out_next.first_level     = pend_lvl_reg;
                        out_next.second_duration = part;
                        out_next.second_level    = lvl_reg;
                        out_next.last_symbol     = last_reg && (rem_after == '0);
                        out_next.error           = 1'b0;
                        out_valid_next           = 1'b1;
                        half_next                = 1'b0;
                        pend_dur_next            = '0;
                        pend_lvl_next            = 1'b0;
                        rem_next                 = rem_after;
                        if (rem_after == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    half_next     = 1'b1;
                    pend_dur_next = part;
                    pend_lvl_next = lvl_reg;
                    rem_next      = rem_after;
                    if (rem_after == '0)
                    begin
                        state_next = last_reg ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (out_ok)
                begin
                    out_next.first_duration  = pend_dur_reg;
                    out_next.first_level     = pend_lvl_reg;
                    out_next.second_duration = PART_W'(1);
                    out_next.second_level    = 1'b0;
                    out_next.last_symbol     = 1'b1;
                    out_next.error           = 1'b0;
                    out_valid_next           = 1'b1;
                    half_next                = 1'b0;
                    pend_dur_next            = '0;
                    pend_lvl_next            = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            half_reg      <= 1'b0;
            pend_dur_reg  <= '0;
            pend_lvl_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            half_reg      <= half_next;
            pend_dur_reg  <= pend_dur_next;
            pend_lvl_reg  <= pend_lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lvl_reg  <= lvl_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

endmodule

// ===== sim/pulse_duration_symbol_packer_unit_tb.sv =====
`timescale 1ns / 1ps

module pulse_duration_symbol_packer_unit_tb;
    import pdsp_pkg::*;

    localparam int MAX_PART   = MAX_PART_DEFAULT;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 27;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_ONE,
        ROW_NONE
    } row_kind_t;

    typedef struct packed {
        pdsp_in_t  stim;
        row_kind_t kind;
        pdsp_out_t want;
    } stim_row_t;

    localparam pdsp_out_t ERROR_WORD = '{15'd0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b1};
    localparam pdsp_out_t NO_WORD    = '0;

    localparam int NUM_ROWS = 21;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{21'd1, 1'b1, 1'b1}, ROW_ONE, '{15'd1, 1'b1, 15'd1, 1'b0, 1'b1, 1'b0}},
        '{'{21'd0, 1'b1, 1'b1}, ROW_ONE, ERROR_WORD},
        '{'{21'd0, 1'b0, 1'b0}, ROW_ONE, ERROR_WORD},
        '{'{21'd5, 1'b1, 1'b0}, ROW_NONE, NO_WORD},
        '{'{21'd0, 1'b0, 1'b1}, ROW_NONE, NO_WORD},
        '{'{21'd32767, 1'b1, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'd32768, 1'b0, 1'b1}, ROW_PREDICT, NO_WORD},
        '{'{21'd2097151, 1'b1, 1'b1}, ROW_PREDICT, NO_WORD},
        '{'{21'h155555, 1'b0, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'h0aaaaa, 1'b1, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'd3, 1'b1, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'd0, 1'b1, 1'b0}, ROW_ONE, ERROR_WORD},
        '{'{21'd7, 1'b1, 1'b1}, ROW_NONE, NO_WORD},
        '{'{21'd32767, 1'b0, 1'b1}, ROW_ONE, '{15'd32767, 1'b0, 15'd1, 1'b0, 1'b1, 1'b0}},
        '{'{21'd100, 1'b1, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'd200, 1'b0, 1'b1}, ROW_PREDICT, NO_WORD},
        '{'{21'd2097151, 1'b0, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'd1, 1'b0, 1'b1}, ROW_PREDICT, NO_WORD},
        '{'{21'd65534, 1'b1, 1'b1}, ROW_PREDICT, NO_WORD},
        '{'{21'd32766, 1'b1, 1'b0}, ROW_PREDICT, NO_WORD},
        '{'{21'd32769, 1'b0, 1'b1}, ROW_PREDICT, NO_WORD}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    pdsp_in_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    pdsp_out_t result;

    pdsp_out_t words_due[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    bit        hold_req = 1'b0;

    // predictor state
    bit                half_waiting = 1'b0;
    logic [PART_W-1:0] half_dur = '0;
    logic              half_lvl = 1'b0;
    bit                dropping = 1'b0;

    pulse_duration_symbol_packer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // returns 0 when the item is swallowed by a dropped sequence
    function automatic bit pack_symbols(input pdsp_in_t it, ref pdsp_out_t made[$]);
        logic [DUR_W-1:0]  left;
        logic [PART_W-1:0] part;
        pdsp_out_t         w;
        left = it.pulse_len;
        if (dropping)
        begin
            if (it.last)
                dropping = 1'b0;
            return 1'b0;
        end
        if (left == '0)
        begin
            made.push_back(ERROR_WORD);
            half_waiting = 1'b0;
            half_dur = '0;
            half_lvl = 1'b0;
            dropping = !it.last;
            return 1'b1;
        end
        while (left != '0)
        begin
            part = (left > DUR_W'(MAX_PART)) ? PART_W'(MAX_PART) : left[PART_W-1:0];
            left = left - DUR_W'(part);
            if (half_waiting)
            begin
                w = '{half_dur, half_lvl, part, it.level, it.last && (left == '0), 1'b0};
                made.push_back(w);
                half_waiting = 1'b0;
                half_dur = '0;
                half_lvl = 1'b0;
            end
            else
            begin
                half_waiting = 1'b1;
                half_dur = part;
                half_lvl = it.level;
            end
        end
        if (it.last && half_waiting)
        begin
            w = '{half_dur, half_lvl, PART_W'(1), 1'b0, 1'b1, 1'b0};
            made.push_back(w);
            half_waiting = 1'b0;
            half_dur = '0;
            half_lvl = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic offer(input pdsp_in_t it, input row_kind_t kind, input pdsp_out_t want,
                         output bit taken);
        pdsp_out_t made[$];
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        taken = pack_symbols(it, made);
        case (kind)
            ROW_PREDICT: foreach (made[i]) words_due.push_back(made[i]);
            ROW_ONE:     words_due.push_back(want);
            default:     ;
        endcase
    endtask

    function automatic void report(input string field, input int want, input int got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    // sender
    initial
    begin
        pdsp_in_t it;
        bit       taken;
        int       phase_items;
        int       seq_len;
        bit       noise;
        int       r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED_ROWS[i])
            offer(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].want, taken);
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                3: begin send_idle_pct = 13; stall_pct = 13; end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    hold_req = 1'b1;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                seq_len = $urandom_range(1, 5);
                noise = ($urandom_range(9) == 0);
                for (int k = 0; k < seq_len; k++)
                begin
                    r = $urandom_range(99);
                    if (r < 4)
                        it.pulse_len = '0;
                    else if (r < 10)
                        it.pulse_len = DUR_W'($urandom_range(1, 2097151));
                    else if (r < 25)
                        it.pulse_len = DUR_W'($urandom_range(32760, 65540));
                    else
                        it.pulse_len = DUR_W'($urandom_range(1, 40000));
                    it.level = 1'($urandom_range(1));
                    it.last = noise ? 1'($urandom_range(1)) : (k == seq_len - 1);
                    offer(it, ROW_PREDICT, NO_WORD, taken);
                    if (taken)
                        phase_items++;
                end
            end
        end
        push <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("pulse_duration_symbol_packer_unit_tb: clean");
        else
            $display("pulse_duration_symbol_packer_unit_tb: errors");
        $finish;
    end

    // receiver and checker
    initial
    begin
        pdsp_out_t want;
        int        hold_left;
        bit        hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                pop <= 1'b0;
            else
            begin
                if (pop && !empty)
                begin
                    if (words_due.size() == 0)
                    begin
                        fail_count++;
                        $error("symbol word with no expectation waiting: %h", result);
                    end
                    else
                    begin
                        want = words_due.pop_front();
                        if (result.first_duration != want.first_duration)
                            report("first_duration", want.first_duration, result.first_duration);
                        if (result.first_level != want.first_level)
                            report("first_level", want.first_level, result.first_level);
                        if (result.second_duration != want.second_duration)
                            report("second_duration", want.second_duration,
                                   result.second_duration);
                        if (result.second_level != want.second_level)
                            report("second_level", want.second_level, result.second_level);
                        if (result.last_symbol != want.last_symbol)
                            report("last_symbol", want.last_symbol, result.last_symbol);
                        if (result.error != want.error)
                            report("error", want.error, result.error);
                    end
                end
                // long hold-off so the input side backs up
                if (hold_req && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (hold_left > 0)
                begin
                    pop <= 1'b0;
                    hold_left--;
                end
                else
                    pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("pulse_duration_symbol_packer_unit_tb: errors");
                $finish;
            end
        end
    end

endmodule
